FILE: rtl/lbc_pkg.sv
`default_nettype none
package lbc_pkg;

  localparam int MAX_ENTRIES     = 256;
  localparam int WORDS_PER_BLOCK = 32;
  localparam int SLOT_W          = $clog2(MAX_ENTRIES);
  localparam int WORD_W          = $clog2(WORDS_PER_BLOCK);
  localparam int BLK_DEPTH       = MAX_ENTRIES * WORDS_PER_BLOCK;
  localparam int STAMP_W         = 32;
  localparam int CFG_W           = 9;

  // command codes
  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_UPDATE = 2'd1;
  localparam logic [1:0] CMD_INSERT = 2'd2;

  // result status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_MISS    = 2'd1;
  localparam logic [1:0] STAT_PRESENT = 2'd2;
  localparam logic [1:0] STAT_OFF     = 2'd3;

  // configuration register indexes
  localparam logic CFG_CACHE_ON = 1'b0;
  localparam logic CFG_ENTRIES  = 1'b1;

  typedef struct packed {
    logic [1:0]  command;
    logic [3:0]  disk_id;
    logic [7:0]  block_id;
    logic [4:0]  word_index;
    logic [63:0] data_word;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] read_word;
    logic [4:0]  read_index;
    logic        last;
  } out_beat_t;

  // classified operation handed from front to back
  typedef enum logic [2:0] {
    OP_OFF,
    OP_BAD,
    OP_LOOKUP,
    OP_UPD0,
    OP_INS0,
    OP_WORD
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [3:0]  disk;
    logic [7:0]  block;
    logic [4:0]  widx;
    logic [63:0] data;
  } cmd_t;

  typedef struct packed {
    logic [3:0]         disk;
    logic [7:0]         block;
    logic [STAMP_W-1:0] stamp;
  } tag_entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_RD_ISSUE,
    S_RD_WAIT
  } fsm_t;

endpackage
`default_nettype wire

FILE: rtl/lru_block_cache.sv
// word beats past zero and refused commands go through the queue to the output
// register, one beat a cycle while the output is not stalled; lookup and word-zero
// beats scan the tags one slot a cycle over the slots in use; a lookup hit then
// streams 32 beats, each read in an issue and a wait state; the tag scan over the
// single-read tag store sets the pace of a 32-word block write
// reset clears valid bits, clock and queue at once
`default_nettype none
module lru_block_cache import lbc_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire in_beat_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_beat_t             out_data,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  logic              cache_on_r, cache_on_nxt;
  logic [CFG_W-1:0]  entries_r, entries_nxt;
  logic              clear;
  logic [SLOT_W-1:0] last_idx;
  logic              q_valid, q_pop;
  cmd_t              q_cmd;

  // configuration writes
  always_comb begin
    cache_on_nxt = cache_on_r;
    entries_nxt  = entries_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_CACHE_ON: cache_on_nxt = cfg_data[0];
        default:      entries_nxt  = cfg_data;
      endcase
    end
  end

  assign clear = cfg_we && (cfg_index == CFG_CACHE_ON) && cfg_data[0] && !cache_on_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cache_on_r <= 1'b0;
      entries_r  <= CFG_W'(MAX_ENTRIES);
    end else begin
      cache_on_r <= cache_on_nxt;
      entries_r  <= entries_nxt;
    end
  end

  // highest slot searched, slots in use held to 2..max
  always_comb begin
    if (entries_r < CFG_W'(2)) begin
      last_idx = SLOT_W'(1);
    end else if (entries_r > CFG_W'(MAX_ENTRIES)) begin
      last_idx = SLOT_W'(MAX_ENTRIES - 1);
    end else begin
      last_idx = SLOT_W'(entries_r - 1'b1);
    end
  end

  lbc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cache_on (cache_on_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop)
  );

  lbc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear     (clear),
    .last_idx  (last_idx),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

FILE: rtl/lbc_ram.sv
`default_nettype none
module lbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // simple dual port, registered read held when idle
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

FILE: rtl/lbc_front.sv
`default_nettype none
module lbc_front import lbc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     cache_on,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_beat_t in_data,
  output logic          q_valid,
  output cmd_t          q_cmd,
  input  wire logic     q_pop
);

  cmd_t       fifo_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  cmd_t       cls;
  logic       push;

  // classify the incoming beat
  always_comb begin
    cls.disk  = in_data.disk_id;
    cls.block = in_data.block_id;
    cls.widx  = in_data.word_index;
    cls.data  = in_data.data_word;
    if (!cache_on) begin
      cls.op = OP_OFF;
    end else begin
      unique case (in_data.command)
        CMD_LOOKUP: cls.op = OP_LOOKUP;
        CMD_UPDATE: cls.op = (in_data.word_index == '0) ? OP_UPD0 : OP_WORD;
        CMD_INSERT: cls.op = (in_data.word_index == '0) ? OP_INS0 : OP_WORD;
        default:    cls.op = OP_BAD;
      endcase
    end
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = fifo_r[rd_ptr_r];

  // two entry queue pointers
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= cls;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/lbc_back.sv
`default_nettype none
module lbc_back import lbc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              clear,
  input  wire logic [SLOT_W-1:0] last_idx,
  input  wire logic              q_valid,
  input  wire cmd_t              q_cmd,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_beat_t              out_data
);

  fsm_t state_r, state_nxt;
  cmd_t cmd_r, cmd_nxt;

  logic [MAX_ENTRIES-1:0] valid_r, valid_nxt;
  logic [STAMP_W-1:0]     clock_r, clock_nxt;
  logic [SLOT_W-1:0]      wslot_r, wslot_nxt;
  logic                   wact_r, wact_nxt;

  logic [SLOT_W-1:0]  scan_addr_r, scan_addr_nxt;
  logic               issue_done_r, issue_done_nxt;
  logic               rd_pend_r, rd_pend_nxt;
  logic [SLOT_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic               hit_found_r, hit_found_nxt;
  logic [SLOT_W-1:0]  hit_idx_r, hit_idx_nxt;
  logic               inv_found_r, inv_found_nxt;
  logic [SLOT_W-1:0]  inv_idx_r, inv_idx_nxt;
  logic [SLOT_W-1:0]  min_idx_r, min_idx_nxt;
  logic [STAMP_W-1:0] min_stamp_r, min_stamp_nxt;
  logic [WORD_W-1:0]  word_r, word_nxt;

  logic      out_valid_r, out_valid_nxt;
  out_beat_t out_r, out_nxt;
  logic      can_out;

  logic              tag_we, tag_re;
  logic [SLOT_W-1:0] tag_waddr, tag_raddr;
  tag_entry_t        tag_wdata, tag_rdata;

  logic                         blk_we, blk_re;
  logic [$clog2(BLK_DEPTH)-1:0] blk_waddr, blk_raddr;
  logic [63:0]                  blk_wdata, blk_rdata;

  logic              scan_end;
  logic [SLOT_W-1:0] victim;

  assign can_out  = !out_valid_r || out_ready;
  assign scan_end = rd_pend_r && (rd_idx_r == last_idx);
  assign victim   = inv_found_r ? inv_idx_r : min_idx_r;

  // tag and stamp store
  lbc_ram #(.WIDTH($bits(tag_entry_t)), .DEPTH(MAX_ENTRIES)) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata (tag_wdata),
    .re    (tag_re),
    .raddr (tag_raddr),
    .rdata (tag_rdata)
  );

  // block data store
  lbc_ram #(.WIDTH(64), .DEPTH(BLK_DEPTH)) u_blk_ram (
    .clk   (clk),
    .we    (blk_we),
    .waddr (blk_waddr),
    .wdata (blk_wdata),
    .re    (blk_re),
    .raddr (blk_raddr),
    .rdata (blk_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid && (q_cmd.op == OP_LOOKUP || q_cmd.op == OP_UPD0 ||
                        q_cmd.op == OP_INS0)) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (can_out) begin
          if (cmd_r.op == OP_LOOKUP && hit_found_r) begin
            state_nxt = S_RD_ISSUE;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_RD_ISSUE: state_nxt = S_RD_WAIT;
      S_RD_WAIT: begin
        if (can_out) begin
          state_nxt = (word_r == WORD_W'(WORDS_PER_BLOCK - 1)) ? S_IDLE : S_RD_ISSUE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cmd_nxt        = cmd_r;
    valid_nxt      = valid_r;
    clock_nxt      = clock_r;
    wslot_nxt      = wslot_r;
    wact_nxt       = wact_r;
    scan_addr_nxt  = scan_addr_r;
    issue_done_nxt = issue_done_r;
    rd_pend_nxt    = 1'b0;
    rd_idx_nxt     = rd_idx_r;
    hit_found_nxt  = hit_found_r;
    hit_idx_nxt    = hit_idx_r;
    inv_found_nxt  = inv_found_r;
    inv_idx_nxt    = inv_idx_r;
    min_idx_nxt    = min_idx_r;
    min_stamp_nxt  = min_stamp_r;
    word_nxt       = word_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_nxt        = out_r;
    q_pop          = 1'b0;
    tag_we         = 1'b0;
    tag_waddr      = hit_idx_r;
    tag_wdata      = '{disk: cmd_r.disk, block: cmd_r.block, stamp: clock_r + 1'b1};
    tag_re         = 1'b0;
    tag_raddr      = scan_addr_r;
    blk_we         = 1'b0;
    blk_waddr      = {wslot_r, q_cmd.widx};
    blk_wdata      = q_cmd.data;
    blk_re         = 1'b0;
    blk_raddr      = {hit_idx_r, word_r};

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          if (q_cmd.op == OP_LOOKUP || q_cmd.op == OP_UPD0 || q_cmd.op == OP_INS0) begin
            q_pop          = 1'b1;
            cmd_nxt        = q_cmd;
            scan_addr_nxt  = '0;
            issue_done_nxt = 1'b0;
            hit_found_nxt  = 1'b0;
            inv_found_nxt  = 1'b0;
          end else if (can_out) begin
            q_pop          = 1'b1;
            out_valid_nxt  = 1'b1;
            out_nxt        = '{status: STAT_MISS, read_word: '0, read_index: '0, last: 1'b1};
            if (q_cmd.op == OP_OFF) begin
              out_nxt.status = STAT_OFF;
            end else if (q_cmd.op == OP_WORD && wact_r) begin
              blk_we         = 1'b1;
              out_nxt.status = STAT_OK;
            end
          end
        end
      end

      S_SCAN: begin
        // issue one tag read a cycle
        if (!issue_done_r) begin
          tag_re      = 1'b1;
          rd_pend_nxt = 1'b1;
          rd_idx_nxt  = scan_addr_r;
          if (scan_addr_r == last_idx) begin
            issue_done_nxt = 1'b1;
          end else begin
            scan_addr_nxt = scan_addr_r + 1'b1;
          end
        end
        // evaluate the entry read last cycle
        if (rd_pend_r) begin
          if (valid_r[rd_idx_r] && !hit_found_r && tag_rdata.disk == cmd_r.disk &&
              tag_rdata.block == cmd_r.block) begin
            hit_found_nxt = 1'b1;
            hit_idx_nxt   = rd_idx_r;
          end
          if (!valid_r[rd_idx_r] && !inv_found_r) begin
            inv_found_nxt = 1'b1;
            inv_idx_nxt   = rd_idx_r;
          end
          if (rd_idx_r == '0 || tag_rdata.stamp < min_stamp_r) begin
            min_idx_nxt   = rd_idx_r;
            min_stamp_nxt = tag_rdata.stamp;
          end
        end
      end

      S_DECIDE: begin
        if (can_out) begin
          out_nxt = '{status: STAT_MISS, read_word: '0, read_index: '0, last: 1'b1};
          blk_wdata = cmd_r.data;
          case (cmd_r.op)
            OP_LOOKUP: begin
              if (hit_found_r) begin
                tag_we    = 1'b1;
                clock_nxt = clock_r + 1'b1;
                word_nxt  = '0;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            OP_UPD0: begin
              out_valid_nxt = 1'b1;
              if (hit_found_r) begin
                tag_we         = 1'b1;
                clock_nxt      = clock_r + 1'b1;
                blk_we         = 1'b1;
                blk_waddr      = {hit_idx_r, WORD_W'(0)};
                wslot_nxt      = hit_idx_r;
                wact_nxt       = 1'b1;
                out_nxt.status = STAT_OK;
              end else begin
                wact_nxt = 1'b0;
              end
            end
            default: begin
              // insert of word zero
              out_valid_nxt = 1'b1;
              if (hit_found_r) begin
                wact_nxt       = 1'b0;
                out_nxt.status = STAT_PRESENT;
              end else begin
                tag_we            = 1'b1;
                tag_waddr         = victim;
                valid_nxt[victim] = 1'b1;
                clock_nxt         = clock_r + 1'b1;
                blk_we            = 1'b1;
                blk_waddr         = {victim, WORD_W'(0)};
                wslot_nxt         = victim;
                wact_nxt          = 1'b1;
                out_nxt.status    = STAT_OK;
              end
            end
          endcase
        end
      end

      S_RD_ISSUE: begin
        blk_re = 1'b1;
      end

      S_RD_WAIT: begin
        if (can_out) begin
          out_valid_nxt = 1'b1;
          out_nxt = '{status: STAT_OK, read_word: blk_rdata, read_index: word_r,
                      last: (word_r == WORD_W'(WORDS_PER_BLOCK - 1))};
          word_nxt = word_r + 1'b1;
        end
      end

      default: ;
    endcase

    // enabling the cache empties it
    if (clear) begin
      valid_nxt = '0;
      clock_nxt = '0;
      wact_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      clock_r     <= '0;
      wslot_r     <= '0;
      wact_r      <= 1'b0;
      out_valid_r <= 1'b0;
      rd_pend_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      clock_r     <= clock_nxt;
      wslot_r     <= wslot_nxt;
      wact_r      <= wact_nxt;
      out_valid_r <= out_valid_nxt;
      rd_pend_r   <= rd_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    scan_addr_r  <= scan_addr_nxt;
    issue_done_r <= issue_done_nxt;
    rd_idx_r     <= rd_idx_nxt;
    hit_found_r  <= hit_found_nxt;
    hit_idx_r    <= hit_idx_nxt;
    inv_found_r  <= inv_found_nxt;
    inv_idx_r    <= inv_idx_nxt;
    min_idx_r    <= min_idx_nxt;
    min_stamp_r  <= min_stamp_nxt;
    word_r       <= word_nxt;
    out_r        <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire
